[hdl/aabb_pkg.sv]
// ----------------------------------------------------------------------------
// aabb_pkg: shared types and constants for the box pair test
// Field widths, register indexes and the packed beat types of both channels.
// ----------------------------------------------------------------------------
package aabb_pkg;

  localparam int COORD_W    = 32;
  localparam int MARGIN_W   = 31;
  localparam int DIST_W     = 34;
  localparam int VOL_W      = 63;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 34;

  localparam logic [CFG_IDX_W-1:0] REG_GROW_MARGIN        = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_LIMIT_EN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_LIMIT       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATION_LIMIT_EN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEPARATION_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_REQUIRE_OVERLAP    = 3'd5;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t a_min_x;
    coord_t a_min_y;
    coord_t a_min_z;
    coord_t a_max_x;
    coord_t a_max_y;
    coord_t a_max_z;
    coord_t b_min_x;
    coord_t b_min_y;
    coord_t b_min_z;
    coord_t b_max_x;
    coord_t b_max_y;
    coord_t b_max_z;
  } item_t;

  typedef struct packed {
    logic              accepted;
    logic [DIST_W-1:0] centre_distance;
    logic [DIST_W-1:0] separation;
    logic              overlap_valid;
    coord_t            overlap_min_x;
    coord_t            overlap_min_y;
    coord_t            overlap_min_z;
    coord_t            overlap_max_x;
    coord_t            overlap_max_y;
    coord_t            overlap_max_z;
    logic [VOL_W-1:0]  isect_volume;
  } result_t;

endpackage

[hdl/aabb_isqrt.sv]
// ----------------------------------------------------------------------------
// aabb_isqrt: pipelined integer square root
// Floor of the root of a 2*OUT_W bit operand, one result bit per stage.
// ----------------------------------------------------------------------------
module aabb_isqrt #(
  parameter int OUT_W = aabb_pkg::DIST_W
) (
  input  logic               clk,
  input  logic               en,
  input  logic [2*OUT_W-1:0] operand,
  output logic [OUT_W-1:0]   root
);

  localparam int RW = OUT_W + 2;

  logic [2*OUT_W-1:0] op_q   [OUT_W];
  logic [RW-1:0]      rem_q  [OUT_W];
  logic [OUT_W-1:0]   root_q [OUT_W];

  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [2*OUT_W-1:0] op_in;
    logic [RW-1:0]      rem_in;
    logic [OUT_W-1:0]   root_in;
    logic [RW-1:0]      rem_sh;
    logic [RW-1:0]      trial;
    logic               ge;

    if (k == 0) begin : g_first
      assign op_in   = operand;
      assign rem_in  = '0;
      assign root_in = '0;
    end else begin : g_next
      assign op_in   = op_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
    end

    assign rem_sh = {rem_in[RW-3:0], op_in[2*OUT_W-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        op_q[k]   <= {op_in[2*OUT_W-3:0], 2'b00};
        rem_q[k]  <= ge ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[OUT_W-2:0], ge};
      end
    end
  end

  assign root = root_q[OUT_W-1];

endmodule

[hdl/aabb_pair_broadphase_test.sv]
// ----------------------------------------------------------------------------
// aabb_pair_broadphase_test: broadphase overlap and separation test
// Grows two boxes by a margin, measures centre distance and gap, builds the
// intersection box and its volume, and accepts or rejects the pair.
// ----------------------------------------------------------------------------
// The block takes one box pair per clock and returns one result beat per
// pair, in order. Seven arithmetic stages are followed by two 34 stage
// square root pipelines, one result bit per stage, and an output register.
// A stalled result beat holds the whole pipeline. The user is to write
// configuration only while no pair is in flight; the block does not enforce it.
module aabb_pair_broadphase_test (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_stall,
  input  aabb_pkg::item_t                     item,
  output logic                                result_valid,
  input  logic                                result_stall,
  output aabb_pkg::result_t                   result,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [aabb_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [aabb_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int W     = aabb_pkg::DIST_W;
  localparam int NSTG  = 7 + W + 1;

  typedef struct packed {
    logic                          inv;
    logic                          hit;
    aabb_pkg::coord_t [2:0]        lo;
    aabb_pkg::coord_t [2:0]        hi;
    logic [aabb_pkg::VOL_W-1:0]    vol;
  } side_t;

  function automatic aabb_pkg::coord_t sat32(input logic signed [32:0] v);
    if (v[32] != v[31]) begin
      return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
    end
    return v[31:0];
  endfunction

  // Configuration registers.
  logic [aabb_pkg::MARGIN_W-1:0] grow_margin;
  logic                          center_limit_enable;
  logic [W-1:0]                  center_limit;
  logic                          separation_limit_enable;
  logic [W-1:0]                  separation_limit;
  logic                          require_overlap;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      grow_margin             <= '0;
      center_limit_enable     <= 1'b0;
      center_limit            <= '0;
      separation_limit_enable <= 1'b0;
      separation_limit        <= '0;
      require_overlap         <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        aabb_pkg::REG_GROW_MARGIN:
          grow_margin <= cfg_data[aabb_pkg::MARGIN_W-1:0];
        aabb_pkg::REG_CENTER_LIMIT_EN:     center_limit_enable <= cfg_data[0];
        aabb_pkg::REG_CENTER_LIMIT:        center_limit <= cfg_data[W-1:0];
        aabb_pkg::REG_SEPARATION_LIMIT_EN: separation_limit_enable <= cfg_data[0];
        aabb_pkg::REG_SEPARATION_LIMIT:    separation_limit <= cfg_data[W-1:0];
        aabb_pkg::REG_REQUIRE_OVERLAP:     require_overlap <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Whole pipeline moves together; it holds only when the result beat waits.
  logic            adv;
  logic [NSTG-1:0] vld;

  assign adv          = !vld[NSTG-1] || !result_stall;
  assign item_stall   = !adv;
  assign result_valid = vld[NSTG-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NSTG-2:0], item_valid};
    end
  end

  // Input unpacking.
  aabb_pkg::coord_t amin [3], amax [3], bmin [3], bmax [3];

  always_comb begin
    amin[0] = item.a_min_x; amin[1] = item.a_min_y; amin[2] = item.a_min_z;
    amax[0] = item.a_max_x; amax[1] = item.a_max_y; amax[2] = item.a_max_z;
    bmin[0] = item.b_min_x; bmin[1] = item.b_min_y; bmin[2] = item.b_min_z;
    bmax[0] = item.b_max_x; bmax[1] = item.b_max_y; bmax[2] = item.b_max_z;
  end

  // Stage 1: inversion flags and corner sums.
  aabb_pkg::coord_t   s1_amin [3], s1_amax [3], s1_bmin [3], s1_bmax [3];
  logic signed [32:0] s1_asum [3], s1_bsum [3];
  logic               s1_inv_a, s1_inv_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_inv_a <= (amin[0] > amax[0]) || (amin[1] > amax[1]) || (amin[2] > amax[2]);
      s1_inv_b <= (bmin[0] > bmax[0]) || (bmin[1] > bmax[1]) || (bmin[2] > bmax[2]);
      for (int i = 0; i < 3; i++) begin
        s1_amin[i] <= amin[i];
        s1_amax[i] <= amax[i];
        s1_bmin[i] <= bmin[i];
        s1_bmax[i] <= bmax[i];
        s1_asum[i] <= $signed({amin[i][31], amin[i]}) + $signed({amax[i][31], amax[i]});
        s1_bsum[i] <= $signed({bmin[i][31], bmin[i]}) + $signed({bmax[i][31], bmax[i]});
      end
    end
  end

  // Stage 2: centre difference magnitudes and grown boxes.
  logic signed [32:0] marg, ea, eb;
  logic signed [33:0] d1 [3], d2 [3];

  assign marg = $signed({2'b00, grow_margin});
  assign ea   = s1_inv_a ? '0 : marg;
  assign eb   = s1_inv_b ? '0 : marg;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d1[i] = $signed({s1_asum[i][32], s1_asum[i]}) - $signed({s1_bsum[i][32], s1_bsum[i]});
      d2[i] = $signed({s1_bsum[i][32], s1_bsum[i]}) - $signed({s1_asum[i][32], s1_asum[i]});
    end
  end

  logic [32:0]        s2_dmag [3];
  logic signed [32:0] s2_ga0 [3], s2_ga1 [3], s2_gb0 [3], s2_gb1 [3];
  logic               s2_inv;

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_inv <= s1_inv_a || s1_inv_b;
      for (int i = 0; i < 3; i++) begin
        s2_dmag[i] <= d1[i][33] ? d2[i][32:0] : d1[i][32:0];
        s2_ga0[i]  <= $signed({s1_amin[i][31], s1_amin[i]}) - ea;
        s2_ga1[i]  <= $signed({s1_amax[i][31], s1_amax[i]}) + ea;
        s2_gb0[i]  <= $signed({s1_bmin[i][31], s1_bmin[i]}) - eb;
        s2_gb1[i]  <= $signed({s1_bmax[i][31], s1_bmax[i]}) + eb;
      end
    end
  end

  // Stage 3: centre squares, per axis gaps and intersection bounds.
  logic signed [33:0] t1 [3], t2 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      t1[i] = $signed({s2_gb0[i][32], s2_gb0[i]}) - $signed({s2_ga1[i][32], s2_ga1[i]});
      t2[i] = $signed({s2_ga0[i][32], s2_ga0[i]}) - $signed({s2_gb1[i][32], s2_gb1[i]});
    end
  end

  logic [65:0]        s3_dsq [3];
  logic [32:0]        s3_gap [3];
  logic signed [32:0] s3_lo [3], s3_hi [3];
  logic               s3_inv;

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_inv <= s2_inv;
      for (int i = 0; i < 3; i++) begin
        s3_dsq[i] <= 66'(s2_dmag[i]) * 66'(s2_dmag[i]);
        if (!t1[i][33] && t1[i] != '0) begin
          s3_gap[i] <= t1[i][32:0];
        end else if (!t2[i][33] && t2[i] != '0) begin
          s3_gap[i] <= t2[i][32:0];
        end else begin
          s3_gap[i] <= '0;
        end
        s3_lo[i] <= (s2_ga0[i] > s2_gb0[i]) ? s2_ga0[i] : s2_gb0[i];
        s3_hi[i] <= (s2_ga1[i] < s2_gb1[i]) ? s2_ga1[i] : s2_gb1[i];
      end
    end
  end

  // Stage 4: centre sum, gap squares, region sizes and saturated bounds.
  logic signed [33:0] sz [3];
  logic               hit3;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sz[i] = $signed({s3_hi[i][32], s3_hi[i]}) - $signed({s3_lo[i][32], s3_lo[i]});
    end
  end

  assign hit3 = (s3_gap[0] == '0) && (s3_gap[1] == '0) && (s3_gap[2] == '0);

  logic [67:0]      s4_csum;
  logic [65:0]      s4_gsq [3];
  logic [32:0]      s4_sz [3];
  logic             s4_rinv, s4_hit, s4_inv;
  aabb_pkg::coord_t s4_lo [3], s4_hi [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_csum <= 68'(s3_dsq[0]) + 68'(s3_dsq[1]) + 68'(s3_dsq[2]);
      s4_rinv <= sz[0][33] || sz[1][33] || sz[2][33];
      s4_hit  <= hit3;
      s4_inv  <= s3_inv;
      for (int i = 0; i < 3; i++) begin
        s4_gsq[i] <= 66'(s3_gap[i]) * 66'(s3_gap[i]);
        s4_sz[i]  <= sz[i][32:0];
        s4_lo[i]  <= hit3 ? sat32(s3_lo[i]) : '0;
        s4_hi[i]  <= hit3 ? sat32(s3_hi[i]) : '0;
      end
    end
  end

  // Stage 5: gap sum and first volume product.
  logic [67:0]      s5_csum, s5_gsum;
  logic [65:0]      s5_p1;
  logic [32:0]      s5_szz;
  logic             s5_vok, s5_hit, s5_inv;
  aabb_pkg::coord_t s5_lo [3], s5_hi [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s5_csum <= s4_csum;
      s5_gsum <= 68'(s4_gsq[0]) + 68'(s4_gsq[1]) + 68'(s4_gsq[2]);
      s5_p1   <= 66'(s4_sz[0]) * 66'(s4_sz[1]);
      s5_szz  <= s4_sz[2];
      s5_vok  <= s4_hit && !s4_rinv;
      s5_hit  <= s4_hit;
      s5_inv  <= s4_inv;
      s5_lo   <= s4_lo;
      s5_hi   <= s4_hi;
    end
  end

  // Stage 6: the 66 by 33 bit product as two partial products.
  logic [67:0]      s6_csum, s6_gsum;
  logic [65:0]      s6_qlo, s6_qhi;
  logic             s6_vok, s6_hit, s6_inv;
  aabb_pkg::coord_t s6_lo [3], s6_hi [3];

  always_ff @(posedge clk) begin
    if (adv) begin
      s6_csum <= s5_csum;
      s6_gsum <= s5_gsum;
      s6_qlo  <= 66'(s5_p1[32:0]) * 66'(s5_szz);
      s6_qhi  <= 66'(s5_p1[65:33]) * 66'(s5_szz);
      s6_vok  <= s5_vok;
      s6_hit  <= s5_hit;
      s6_inv  <= s5_inv;
      s6_lo   <= s5_lo;
      s6_hi   <= s5_hi;
    end
  end

  // Stage 7: volume assembly, fraction drop and saturation.
  logic [98:0] prod;

  assign prod = {s6_qhi, 33'd0} + 99'(s6_qlo);

  logic [67:0] s7_csum, s7_gsum;
  side_t       s7_side;

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_csum      <= s6_csum;
      s7_gsum      <= s6_gsum;
      s7_side.inv  <= s6_inv;
      s7_side.hit  <= s6_hit;
      for (int i = 0; i < 3; i++) begin
        s7_side.lo[i] <= s6_lo[i];
        s7_side.hi[i] <= s6_hi[i];
      end
      if (!s6_vok) begin
        s7_side.vol <= '0;
      end else if (prod[98:95] != '0) begin
        s7_side.vol <= '1;
      end else begin
        s7_side.vol <= prod[94:32];
      end
    end
  end

  // Square roots, with the side data delayed to match.
  logic [W-1:0] c_root, g_root;
  side_t        side_q [W];

  aabb_isqrt #(.OUT_W(W)) u_csqrt (
    .clk     (clk),
    .en      (adv),
    .operand (s7_csum),
    .root    (c_root)
  );

  aabb_isqrt #(.OUT_W(W)) u_gsqrt (
    .clk     (clk),
    .en      (adv),
    .operand (s7_gsum),
    .root    (g_root)
  );

  always_ff @(posedge clk) begin
    if (adv) begin
      side_q[0] <= s7_side;
      for (int k = 1; k < W; k++) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  // Output stage: limits and the result beat.
  side_t        fin;
  logic [W-1:0] cdist, sep;
  logic         ok;

  assign fin   = side_q[W-1];
  assign cdist = {1'b0, c_root[W-1:1]};
  assign sep   = fin.inv ? '1 : g_root;
  assign ok    = !(center_limit_enable && (cdist > center_limit)) &&
                 !(separation_limit_enable && (fin.inv || (sep > separation_limit))) &&
                 !(require_overlap && !fin.hit);

  always_ff @(posedge clk) begin
    if (adv) begin
      result.accepted        <= ok;
      result.centre_distance <= cdist;
      result.separation      <= sep;
      result.overlap_valid   <= fin.hit;
      result.overlap_min_x   <= fin.lo[0];
      result.overlap_min_y   <= fin.lo[1];
      result.overlap_min_z   <= fin.lo[2];
      result.overlap_max_x   <= fin.hi[0];
      result.overlap_max_y   <= fin.hi[1];
      result.overlap_max_z   <= fin.hi[2];
      result.isect_volume    <= fin.vol;
    end
  end

endmodule

[tb/aabb_pair_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aabb_pair_checker: result checker for the box pair test
// Watches the pair, result and register channels, keeps its own copy of the
// register settings, predicts each result beat and compares it field by field.
// ----------------------------------------------------------------------------
module aabb_pair_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            item_valid,
  input  logic                            item_stall,
  input  aabb_pkg::item_t                 item,
  input  logic                            result_valid,
  input  logic                            result_stall,
  input  aabb_pkg::result_t               result,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [aabb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aabb_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              mismatches,
  output int                              pending,
  output int                              beats_checked,
  output int                              accepted_seen,
  output int                              overlaps_seen
);

  localparam logic [63:0] ALL34 = 64'h3_FFFF_FFFF;
  localparam logic [63:0] ALL63 = 64'h7FFF_FFFF_FFFF_FFFF;

  logic [aabb_pkg::MARGIN_W-1:0] margin;
  logic                          center_en;
  logic [aabb_pkg::DIST_W-1:0]   center_max;
  logic                          sep_en;
  logic [aabb_pkg::DIST_W-1:0]   sep_max;
  logic                          need_overlap;

  aabb_pkg::result_t expected_results[$];

  function automatic logic [63:0] floor_root(logic [127:0] s);
    logic [127:0] r;
    logic [127:0] c;
    r = '0;
    for (int b = 40; b >= 0; b--) begin
      c = r | (128'd1 << b);
      if (c * c <= s) r = c;
    end
    return r[63:0];
  endfunction

  function automatic aabb_pkg::coord_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic aabb_pkg::result_t pair_result(aabb_pkg::item_t it);
    longint amin[3], amax[3], bmin[3], bmax[3], lo[3], hi[3];
    longint ga0, ga1, gb0, gb1, d, gap, ea, eb;
    bit inv_a, inv_b, hit, region_inv, ok;
    logic [127:0] csum, gsum, t, prod;
    logic [63:0] cdist, sep, vol;
    aabb_pkg::result_t r;
    amin = '{it.a_min_x, it.a_min_y, it.a_min_z};
    amax = '{it.a_max_x, it.a_max_y, it.a_max_z};
    bmin = '{it.b_min_x, it.b_min_y, it.b_min_z};
    bmax = '{it.b_max_x, it.b_max_y, it.b_max_z};
    inv_a = 0;
    inv_b = 0;
    hit = 1;
    region_inv = 0;
    csum = '0;
    gsum = '0;
    for (int i = 0; i < 3; i++) begin
      if (amin[i] > amax[i]) inv_a = 1;
      if (bmin[i] > bmax[i]) inv_b = 1;
    end
    for (int i = 0; i < 3; i++) begin
      ea = inv_a ? 0 : longint'(margin);
      eb = inv_b ? 0 : longint'(margin);
      d = (amin[i] + amax[i]) - (bmin[i] + bmax[i]);
      t = 128'((d < 0) ? -d : d);
      csum += t * t;
      ga0 = amin[i] - ea;
      ga1 = amax[i] + ea;
      gb0 = bmin[i] - eb;
      gb1 = bmax[i] + eb;
      gap = 0;
      if (ga1 < gb0) gap = gb0 - ga1;
      else if (gb1 < ga0) gap = ga0 - gb1;
      if (gap != 0) hit = 0;
      t = 128'(gap);
      gsum += t * t;
      lo[i] = (ga0 > gb0) ? ga0 : gb0;
      hi[i] = (ga1 < gb1) ? ga1 : gb1;
      if (lo[i] > hi[i]) region_inv = 1;
    end
    cdist = floor_root(csum) >> 1;
    if (cdist > ALL34) cdist = ALL34;
    sep = floor_root(gsum);
    if (sep > ALL34 || inv_a || inv_b) sep = ALL34;
    vol = '0;
    if (hit && !region_inv) begin
      prod = 128'(hi[0] - lo[0]) * 128'(hi[1] - lo[1]) * 128'(hi[2] - lo[2]);
      prod = prod >> 32;
      vol = (prod > ALL63) ? ALL63 : prod[63:0];
    end
    ok = 1;
    if (center_en && cdist > center_max) ok = 0;
    if (sep_en && (inv_a || inv_b || sep > sep_max)) ok = 0;
    if (need_overlap && !hit) ok = 0;
    r = '0;
    r.accepted = ok;
    r.centre_distance = cdist[aabb_pkg::DIST_W-1:0];
    r.separation = sep[aabb_pkg::DIST_W-1:0];
    r.overlap_valid = hit;
    if (hit) begin
      r.overlap_min_x = clamp32(lo[0]);
      r.overlap_min_y = clamp32(lo[1]);
      r.overlap_min_z = clamp32(lo[2]);
      r.overlap_max_x = clamp32(hi[0]);
      r.overlap_max_y = clamp32(hi[1]);
      r.overlap_max_z = clamp32(hi[2]);
    end
    r.isect_volume = vol[aabb_pkg::VOL_W-1:0];
    return r;
  endfunction

  function automatic int check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    aabb_pkg::result_t want;
    int errs;
    errs = 0;
    if (rst) begin
      margin <= '0;
      center_en <= 1'b0;
      center_max <= '0;
      sep_en <= 1'b0;
      sep_max <= '0;
      need_overlap <= 1'b0;
      expected_results.delete();
      mismatches <= 0;
      pending <= 0;
      beats_checked <= 0;
      accepted_seen <= 0;
      overlaps_seen <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aabb_pkg::REG_GROW_MARGIN:
            margin <= cfg_data[aabb_pkg::MARGIN_W-1:0];
          aabb_pkg::REG_CENTER_LIMIT_EN:     center_en <= cfg_data[0];
          aabb_pkg::REG_CENTER_LIMIT:        center_max <= cfg_data;
          aabb_pkg::REG_SEPARATION_LIMIT_EN: sep_en <= cfg_data[0];
          aabb_pkg::REG_SEPARATION_LIMIT:    sep_max <= cfg_data;
          aabb_pkg::REG_REQUIRE_OVERLAP:     need_overlap <= cfg_data[0];
          default: ;
        endcase
      end
      if (item_valid && !item_stall) begin
        expected_results.insert(expected_results.size(), pair_result(item));
      end
      if (result_valid && !result_stall) begin
        beats_checked <= beats_checked + 1;
        if (result.accepted) accepted_seen <= accepted_seen + 1;
        if (result.overlap_valid) overlaps_seen <= overlaps_seen + 1;
        if (expected_results.size() == 0) begin
          errs = 1;
          $display("%0t: result beat with nothing expected, actual %h", $time, result);
        end else begin
          want = expected_results.pop_front();
          errs += check_field("accepted", 64'(want.accepted), 64'(result.accepted));
          errs += check_field("centre_distance", 64'(want.centre_distance),
                              64'(result.centre_distance));
          errs += check_field("separation", 64'(want.separation),
                              64'(result.separation));
          errs += check_field("overlap_valid", 64'(want.overlap_valid),
                              64'(result.overlap_valid));
          errs += check_field("overlap_min_x", 64'(want.overlap_min_x),
                              64'(result.overlap_min_x));
          errs += check_field("overlap_min_y", 64'(want.overlap_min_y),
                              64'(result.overlap_min_y));
          errs += check_field("overlap_min_z", 64'(want.overlap_min_z),
                              64'(result.overlap_min_z));
          errs += check_field("overlap_max_x", 64'(want.overlap_max_x),
                              64'(result.overlap_max_x));
          errs += check_field("overlap_max_y", 64'(want.overlap_max_y),
                              64'(result.overlap_max_y));
          errs += check_field("overlap_max_z", 64'(want.overlap_max_z),
                              64'(result.overlap_max_z));
          errs += check_field("isect_volume", 64'(want.isect_volume),
                              64'(result.isect_volume));
        end
        mismatches <= mismatches + errs;
      end
      pending <= expected_results.size();
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the box pair broadphase test
// Writes several register settings, sends directed and random box pairs with
// random gaps and result stalls, and reports the verdict from the checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam aabb_pkg::coord_t CMIN = 32'sh8000_0000;
  localparam aabb_pkg::coord_t CMAX = 32'sh7FFF_FFFF;
  localparam int               PAIRS_PER_PHASE = 250;

  logic                            clk;
  logic                            rst;
  logic                            item_valid;
  logic                            item_stall;
  aabb_pkg::item_t                 item;
  logic                            result_valid;
  logic                            result_stall;
  aabb_pkg::result_t               result;
  logic                            cfg_valid;
  logic                            cfg_ready;
  logic [aabb_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [aabb_pkg::CFG_DATA_W-1:0] cfg_data;
  int                              mismatches;
  int                              pending;
  int                              beats_checked;
  int                              accepted_seen;
  int                              overlaps_seen;
  bit                              steady;
  int                              pairs_sent;

  aabb_pair_broadphase_test dut (.*);

  aabb_pair_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("aabb_pair_broadphase_test test failed");
    $finish;
  end

  // Result side: random stall before each beat, none while steady is set.
  initial begin
    result_stall <= 1'b1;
    @(negedge clk);
    forever begin
      int n;
      n = steady ? 0 : $urandom_range(0, 5);
      if (n > 0) begin
        result_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      result_stall <= 1'b0;
      do @(posedge clk); while (!result_valid);
      @(negedge clk);
    end
  end

  task automatic write_reg(logic [aabb_pkg::CFG_IDX_W-1:0] idx,
                           logic [aabb_pkg::CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  task automatic drain();
    item_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
  endtask

  task automatic set_regs(logic [aabb_pkg::MARGIN_W-1:0] m, bit cen,
                          logic [aabb_pkg::DIST_W-1:0] cl, bit sen,
                          logic [aabb_pkg::DIST_W-1:0] sl, bit ov);
    drain();
    write_reg(aabb_pkg::REG_GROW_MARGIN, 34'(m));
    write_reg(aabb_pkg::REG_CENTER_LIMIT_EN, 34'(cen));
    write_reg(aabb_pkg::REG_CENTER_LIMIT, cl);
    write_reg(aabb_pkg::REG_SEPARATION_LIMIT_EN, 34'(sen));
    write_reg(aabb_pkg::REG_SEPARATION_LIMIT, sl);
    write_reg(aabb_pkg::REG_REQUIRE_OVERLAP, 34'(ov));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_pair(aabb_pkg::item_t p);
    int n;
    n = steady ? 0 : $urandom_range(0, 5);
    if (n > 0) begin
      item_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= p;
    do @(posedge clk); while (item_stall);
    @(negedge clk);
    pairs_sent++;
  endtask

  function automatic aabb_pkg::item_t make_pair(aabb_pkg::coord_t lo0, aabb_pkg::coord_t hi0,
                                                aabb_pkg::coord_t lo1, aabb_pkg::coord_t hi1);
    aabb_pkg::item_t p;
    p = '{lo0, lo0, lo0, hi0, hi0, hi0, lo1, lo1, lo1, hi1, hi1, hi1};
    return p;
  endfunction

  function automatic aabb_pkg::coord_t pick_coord(int mode);
    case (mode)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
      default: begin
        case ($urandom_range(0, 5))
          0: return CMIN;
          1: return CMAX;
          2: return 0;
          3: return -1;
          4: return 1;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Fills one box; mostly well formed and near the origin so pairs overlap.
  task automatic make_box(output aabb_pkg::coord_t lo[3], output aabb_pkg::coord_t hi[3]);
    int mode;
    aabb_pkg::coord_t a, b, t;
    bit flip;
    mode = $urandom_range(0, 9);
    mode = (mode < 6) ? 1 : (mode < 8) ? 0 : 2;
    flip = ($urandom_range(0, 9) == 0);
    for (int i = 0; i < 3; i++) begin
      a = pick_coord(mode);
      if (mode == 1) b = a + $signed($urandom_range(0, 32'h0004_0000));
      else b = pick_coord(mode);
      if (a > b) begin
        t = a;
        a = b;
        b = t;
      end
      lo[i] = a;
      hi[i] = b;
    end
    if (flip) begin
      int k;
      k = $urandom_range(0, 2);
      t = lo[k];
      lo[k] = hi[k] + 1;
      hi[k] = t;
      if (lo[k] <= hi[k]) lo[k] = CMAX;
      if (lo[k] <= hi[k]) hi[k] = CMIN;
    end
  endtask

  task automatic random_pairs(int count);
    aabb_pkg::coord_t alo[3], ahi[3], blo[3], bhi[3];
    aabb_pkg::item_t p;
    for (int i = 0; i < count; i++) begin
      steady = ((i / 60) % 4 == 3);
      make_box(alo, ahi);
      make_box(blo, bhi);
      p = '{alo[0], alo[1], alo[2], ahi[0], ahi[1], ahi[2],
            blo[0], blo[1], blo[2], bhi[0], bhi[1], bhi[2]};
      send_pair(p);
    end
    steady = 0;
  endtask

  initial begin
    rst <= 1'b1;
    item_valid <= 1'b0;
    item <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    steady = 0;
    pairs_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed pairs at reset settings, then again with the largest margin.
    for (int pass = 0; pass < 2; pass++) begin
      if (pass == 1) set_regs('1, 1'b1, 34'h1_0000, 1'b1, 34'h1_0000, 1'b1);
      send_pair(make_pair(CMIN, CMAX, CMIN, CMAX));
      send_pair(make_pair(CMIN, CMIN, CMAX, CMAX));
      send_pair(make_pair(0, 0, 0, 0));
      send_pair(make_pair(0, 32'sh1_0000, 32'sh1_0000, 32'sh2_0000));
      send_pair(make_pair(0, 32'sh1_0000, 32'sh3_0000, 32'sh4_0000));
      send_pair(make_pair(32'sh1_0000, 0, 0, 32'sh1_0000));
      send_pair(make_pair(0, 32'sh1_0000, 32'sh1_0000, 0));
      send_pair(make_pair(32'sha, 0, -32'sh5, 32'sh14));
      send_pair(make_pair(CMAX, CMIN, CMAX, CMIN));
      send_pair(make_pair(-1, 1, -1, 1));
      send_pair('1);
      send_pair(make_pair(CMIN, CMIN, CMIN, CMIN));
    end

    // Pause until everything is back before random traffic starts.
    drain();

    set_regs('0, 1'b0, '0, 1'b0, '0, 1'b0);
    random_pairs(PAIRS_PER_PHASE);
    set_regs('1, 1'b1, '1, 1'b1, '1, 1'b1);
    random_pairs(PAIRS_PER_PHASE);
    set_regs(31'h0001_0000, 1'b1, 34'h0004_0000, 1'b0, '0, 1'b1);
    random_pairs(PAIRS_PER_PHASE);
    set_regs(31'h0000_8000, 1'b0, '0, 1'b1, 34'h0002_0000, 1'b0);
    random_pairs(PAIRS_PER_PHASE);
    set_regs(31'($urandom), 1'b1, {$urandom, 2'b0}, 1'b1, {$urandom, 2'b1},
             1'($urandom_range(0, 1)));
    random_pairs(PAIRS_PER_PHASE);
    set_regs('0, 1'b1, '0, 1'b1, '0, 1'b1);
    random_pairs(PAIRS_PER_PHASE);

    drain();
    $display("Sent %0d box pairs over eight register settings; checked %0d results.",
             pairs_sent, beats_checked);
    $display("Results accepted: %0d, with grown boxes overlapping: %0d.",
             accepted_seen, overlaps_seen);
    if (mismatches == 0 && pending == 0) begin
      $display("aabb_pair_broadphase_test test passed");
    end else begin
      $display("aabb_pair_broadphase_test test failed");
    end
    $finish;
  end

endmodule
